// File: design/fas_pkg.sv
`timescale 1ns / 1ps
// Shared widths, operation and result codes, and the queue entry type.
package fas_pkg;

  localparam int FUNC_W = 3;
  localparam int RID_W  = 22;
  localparam int UID_W  = 16;
  localparam int KIND_W = 3;
  localparam int CFG_W  = 5;

  localparam logic [FUNC_W-1:0] FN_EXECUTE  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FINISHED = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CONSULT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SHUTDOWN = 3'd3;

  localparam logic [KIND_W-1:0] KD_GRANT      = 3'd0;
  localparam logic [KIND_W-1:0] KD_REF_OFF    = 3'd1;
  localparam logic [KIND_W-1:0] KD_REF_UNKN   = 3'd2;
  localparam logic [KIND_W-1:0] KD_SHUT_ACK   = 3'd3;
  localparam logic [KIND_W-1:0] KD_RUN_ENTRY  = 3'd4;
  localparam logic [KIND_W-1:0] KD_PEND_ENTRY = 3'd5;
  localparam logic [KIND_W-1:0] KD_CONS_END   = 3'd6;
  localparam logic [KIND_W-1:0] KD_REF_FULL   = 3'd7;

  typedef struct packed {
    logic [RID_W-1:0] runner;
    logic [UID_W-1:0] user;
  } entry_t;

endpackage

// File: design/fas_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result items.
interface fas_in_if import fas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [RID_W-1:0]  runner_id;
  logic [UID_W-1:0]  user_id;

  modport source (output valid, output func, output runner_id, output user_id, input ready);
  modport sink   (input valid, input func, input runner_id, input user_id, output ready);
endinterface

interface fas_out_if import fas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [RID_W-1:0]  target_id;
  logic [UID_W-1:0]  listed_user;
  logic              last;

  modport source (output valid, output kind, output target_id, output listed_user,
                  output last, input ready);
  modport sink   (input valid, input kind, input target_id, input listed_user,
                  input last, output ready);
endinterface

// File: design/fcfs_admission_scheduler_top.sv
`timescale 1ns / 1ps
// A refusal, shutdown ack or unknown item goes through the single-result state into the result register.
// Each grant steps through a pending memory read, then a write into the running memory.
// A finished item scans the running memory, then grants.
// Consult reads and sends each entry of the running list, then of the pending list, then the end item.
// One request at a time; the next is accepted once the block is back in idle.
// Reset (synchronous): both lists empty, limit one, block on; memory contents are not cleared.
module fcfs_admission_scheduler_top import fas_pkg::*; #(
  parameter int RUN_SLOTS     = 16,
  parameter int PENDING_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  fas_in_if.sink           req,
  fas_out_if.source        rsp,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int RIW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
  localparam int CW  = $clog2(RUN_SLOTS + 1);
  localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int XW  = (CW > PCW) ? CW : PCW;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SINGLE   = 4'd1;
  localparam logic [3:0] ST_G_RD     = 4'd2;
  localparam logic [3:0] ST_G_EM     = 4'd3;
  localparam logic [3:0] ST_F_SCAN   = 4'd4;
  localparam logic [3:0] ST_C_RUN_RD = 4'd5;
  localparam logic [3:0] ST_C_RUN_EM = 4'd6;
  localparam logic [3:0] ST_C_PEN_RD = 4'd7;
  localparam logic [3:0] ST_C_PEN_EM = 4'd8;

  logic [3:0]        state;
  logic [CFG_W-1:0]  run_limit;
  logic              accepting;
  logic [CW-1:0]     run_count;
  logic [PIW-1:0]    pend_head;
  logic [PCW-1:0]    pend_count;
  logic [RID_W-1:0]  req_rid;
  logic [KIND_W-1:0] sing_kind;
  logic [XW-1:0]     cidx;
  logic [PIW-1:0]    pend_ptr;
  logic              found;
  logic              scan_rvalid;
  logic [RIW-1:0]    scan_ridx;

  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [RID_W-1:0]  out_id;
  logic [UID_W-1:0]  out_user;
  logic              out_last;

  entry_t run_mem [RUN_SLOTS];
  entry_t pend_mem [PENDING_DEPTH];
  entry_t run_rdata;
  entry_t pend_rdata;

  logic           run_re, run_we, pend_re, pend_we;
  logic [RIW-1:0] run_raddr, run_waddr;
  logic [PIW-1:0] pend_raddr, pend_waddr;
  entry_t         run_wdata, pend_wdata;

  logic              accept, out_free, emit, emit_last;
  logic [KIND_W-1:0] emit_kind;
  logic [RID_W-1:0]  emit_id;
  logic [UID_W-1:0]  emit_user;
  logic [CW-1:0]     lim;
  logic [PCW:0]      tail_sum;
  logic [PIW-1:0]    tail;
  logic              scan_issue, grant_more;

  function automatic logic [PIW-1:0] ptr_inc(input logic [PIW-1:0] p);
    return (p == PIW'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);

  // Effective limit: zero acts as one, anything above the slot count is clamped.
  always_comb begin
    if (run_limit == '0) begin
      lim = CW'(1);
    end else if ({1'b0, run_limit} > 6'(RUN_SLOTS)) begin
      lim = CW'(RUN_SLOTS);
    end else begin
      lim = CW'(run_limit);
    end
  end

  assign tail_sum = (PCW+1)'(pend_head) + (PCW+1)'(pend_count);
  assign tail = (tail_sum >= (PCW+1)'(PENDING_DEPTH)) ?
                PIW'(tail_sum - (PCW+1)'(PENDING_DEPTH)) : PIW'(tail_sum);

  assign scan_issue = (state == ST_F_SCAN) && (cidx < XW'(run_count));
  assign grant_more = ((run_count + CW'(1)) < lim) && (pend_count != PCW'(1));

  // Memory port control and result generation.
  always_comb begin
    run_re     = 1'b0;
    run_raddr  = cidx[RIW-1:0];
    run_we     = 1'b0;
    run_waddr  = scan_ridx - 1'b1;
    run_wdata  = run_rdata;
    pend_re    = 1'b0;
    pend_raddr = pend_head;
    pend_we    = 1'b0;
    pend_waddr = tail;
    pend_wdata = '{runner: req.runner_id, user: req.user_id};
    emit       = 1'b0;
    emit_kind  = sing_kind;
    emit_id    = req_rid;
    emit_user  = '0;
    emit_last  = 1'b1;
    case (state)
      ST_IDLE: begin
        pend_we = accept && (req.func == FN_EXECUTE) && accepting &&
                  (pend_count != PCW'(PENDING_DEPTH));
      end
      ST_SINGLE: begin
        emit = out_free;
      end
      ST_G_RD: begin
        pend_re = (run_count < lim) && (pend_count != '0);
      end
      ST_G_EM: begin
        emit      = out_free;
        run_we    = out_free;
        run_waddr = run_count[RIW-1:0];
        run_wdata = pend_rdata;
        emit_kind = KD_GRANT;
        emit_id   = pend_rdata.runner;
        emit_last = !grant_more;
      end
      ST_F_SCAN: begin
        run_re = scan_issue;
        // Entries after the removed one move down by one slot.
        run_we = scan_rvalid && found;
      end
      ST_C_RUN_RD: begin
        run_re = (cidx < XW'(run_count));
      end
      ST_C_RUN_EM: begin
        emit      = out_free;
        emit_kind = KD_RUN_ENTRY;
        emit_id   = run_rdata.runner;
        emit_user = run_rdata.user;
        emit_last = 1'b0;
      end
      ST_C_PEN_RD: begin
        pend_re    = (cidx < XW'(pend_count));
        pend_raddr = pend_ptr;
      end
      ST_C_PEN_EM: begin
        emit      = out_free;
        emit_kind = KD_PEND_ENTRY;
        emit_id   = pend_rdata.runner;
        emit_user = pend_rdata.user;
        emit_last = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[run_waddr] <= run_wdata;
    end
    if (run_re) begin
      run_rdata <= run_mem[run_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    if (pend_re) begin
      pend_rdata <= pend_mem[pend_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_kind <= emit_kind;
      out_id   <= emit_id;
      out_user <= emit_user;
      out_last <= emit_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.target_id   = out_id;
  assign rsp.listed_user = out_user;
  assign rsp.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_limit <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      run_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      accepting   <= 1'b1;
      run_count   <= '0;
      pend_head   <= '0;
      pend_count  <= '0;
      found       <= 1'b0;
      scan_rvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_rid <= req.runner_id;
            case (req.func)
              FN_EXECUTE: begin
                if (!accepting) begin
                  sing_kind <= KD_REF_OFF;
                  state     <= ST_SINGLE;
                end else if (pend_count == PCW'(PENDING_DEPTH)) begin
                  sing_kind <= KD_REF_FULL;
                  state     <= ST_SINGLE;
                end else begin
                  pend_count <= pend_count + 1'b1;
                  state      <= ST_G_RD;
                end
              end
              FN_FINISHED: begin
                cidx        <= '0;
                found       <= 1'b0;
                scan_rvalid <= 1'b0;
                state       <= ST_F_SCAN;
              end
              FN_CONSULT: begin
                cidx  <= '0;
                state <= ST_C_RUN_RD;
              end
              FN_SHUTDOWN: begin
                accepting <= 1'b0;
                sing_kind <= KD_SHUT_ACK;
                state     <= ST_SINGLE;
              end
              default: begin
                sing_kind <= KD_REF_UNKN;
                state     <= ST_SINGLE;
              end
            endcase
          end
        end
        ST_SINGLE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_G_RD: begin
          state <= pend_re ? ST_G_EM : ST_IDLE;
        end
        ST_G_EM: begin
          if (out_free) begin
            pend_head  <= ptr_inc(pend_head);
            pend_count <= pend_count - 1'b1;
            run_count  <= run_count + 1'b1;
            state      <= ST_G_RD;
          end
        end
        ST_F_SCAN: begin
          scan_rvalid <= scan_issue;
          scan_ridx   <= cidx[RIW-1:0];
          if (scan_issue) begin
            cidx <= cidx + 1'b1;
          end
          // Only the earliest matching entry is removed.
          if (scan_rvalid && !found && (run_rdata.runner == req_rid)) begin
            found <= 1'b1;
          end
          if (!scan_issue && !scan_rvalid) begin
            if (found) begin
              run_count <= run_count - 1'b1;
            end
            state <= ST_G_RD;
          end
        end
        ST_C_RUN_RD: begin
          if (run_re) begin
            state <= ST_C_RUN_EM;
          end else begin
            cidx     <= '0;
            pend_ptr <= pend_head;
            state    <= ST_C_PEN_RD;
          end
        end
        ST_C_RUN_EM: begin
          if (out_free) begin
            cidx  <= cidx + 1'b1;
            state <= ST_C_RUN_RD;
          end
        end
        ST_C_PEN_RD: begin
          if (pend_re) begin
            state <= ST_C_PEN_EM;
          end else begin
            sing_kind <= KD_CONS_END;
            state     <= ST_SINGLE;
          end
        end
        ST_C_PEN_EM: begin
          if (out_free) begin
            cidx     <= cidx + 1'b1;
            pend_ptr <= ptr_inc(pend_ptr);
            state    <= ST_C_PEN_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || rsp.ready))
    else $error("result register overwritten while still held");

  a_grant_under_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_G_EM) |-> ((run_count < lim) && (pend_count != '0)))
    else $error("grant issued without a free slot or a pending job");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (run_count <= CW'(RUN_SLOTS)) && (pend_count <= PCW'(PENDING_DEPTH)))
    else $error("list occupancy out of range");

  a_shift_after_match: assert property (@(posedge clk) disable iff (rst)
    run_we && (state == ST_F_SCAN) |-> (found && (scan_ridx != '0)))
    else $error("running list shift without an earlier match");

endmodule
